### rtl/osc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osc_pkg: shared constants and types of the shadow cone core
// Field widths, fixed-point layout and the records that move between the
// front end, the square-root pipe, the divider pipe and the scaling stage.
// ---------------------------------------------------------------------------
package osc_pkg;

  // Coordinate width of the input fields.
  localparam int COORD_BITS = 10;
  // Fraction bits of the fixed-point unit vectors and roots.
  localparam int FRAC       = 16;
  // Clearance radius width and reset value.
  localparam int RW         = 8;
  localparam logic [RW-1:0] RADIUS_RST = RW'(18);
  // Width of each output corner coordinate.
  localparam int OUTW       = 13;

  // Derived widths.
  localparam int DW    = COORD_BITS + 1;             // signed delta
  localparam int SQW   = 2 * COORD_BITS;             // one squared delta
  localparam int D2W   = 2 * COORD_BITS + 1;         // squared distance
  localparam int R2W   = 2 * RW;                     // squared radius
  localparam int RADW  = D2W + 1;                    // radicand d2 +/- r2
  localparam int ROOTW = (RADW + 2 * FRAC) / 2;      // Q16 root
  localparam int REMW  = ROOTW + 2;                  // root remainder
  localparam int NUMW  = DW + ROOTW + 1;             // signed numerator
  localparam int MAGW  = NUMW - 1;                   // numerator magnitude
  localparam int QW    = FRAC + 1;                   // unit component magnitude
  localparam int DREMW = D2W + 1;                    // divider remainder
  localparam int PRODW = ROOTW + QW;                 // length times unit
  localparam int OFFW  = PRODW - 2 * FRAC;           // pixel offset magnitude
  localparam int SUMW  = (OFFW + 2 > OUTW) ? OFFW + 2 : OUTW + 1;

  localparam logic signed [SUMW-1:0] OUT_MAX = SUMW'((2 ** (OUTW - 1)) - 1);
  localparam logic signed [SUMW-1:0] OUT_MIN = SUMW'(-(2 ** (OUTW - 1)));

  // Four components: cos and sin of theta+a, then cos and sin of theta-a.
  localparam int NLANE   = 4;
  localparam int LANE_C1 = 0;
  localparam int LANE_S1 = 1;
  localparam int LANE_C2 = 2;
  localparam int LANE_S2 = 3;

  // Geometry that travels beside the square roots.
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic [D2W-1:0]        d2;
    logic [RW-1:0]         r;
    logic                  close;
  } osc_side_t;

  // One digit-by-digit square root in flight.
  typedef struct packed {
    logic [2*ROOTW-1:0] rad;
    logic [REMW-1:0]    rem;
    logic [ROOTW-1:0]   root;
  } osc_root_lane_t;

  // One restoring division in flight; bits holds the dividend tail and
  // collects the quotient from the bottom.
  typedef struct packed {
    logic             neg;
    logic [DREMW-1:0] rem;
    logic [QW-1:0]    bits;
  } osc_div_lane_t;

  // What the back end still needs besides the unit components.
  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [ROOTW-1:0]      len;
    logic                  close;
  } osc_tail_t;

endpackage
`default_nettype wire

### rtl/osc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osc_front: deltas, squared distance and radicands
// Three stages: deltas, squares, then the squared distance, the too-close
// compare and the two radicands d2 - r2 and d2 + r2.
// ---------------------------------------------------------------------------
module osc_front
  import osc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_px,
  input  logic [COORD_BITS-1:0] in_py,
  input  logic [COORD_BITS-1:0] in_ox,
  input  logic [COORD_BITS-1:0] in_oy,
  input  logic [RW-1:0]         in_radius,
  output logic                  out_valid,
  input  logic                  out_ready,
  output osc_side_t             out_side,
  output logic [RADW-1:0]       out_rad_s,
  output logic [RADW-1:0]       out_rad_l
);

  localparam int N = 3;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N-1:0] take;

  logic [COORD_BITS-1:0] a_px_r, a_py_r;
  logic signed [DW-1:0]  a_dx_r, a_dy_r;
  logic [RW-1:0]         a_r_r;
  logic signed [DW-1:0]  a_dx_nxt, a_dy_nxt;

  logic [COORD_BITS-1:0] b_px_r, b_py_r;
  logic signed [DW-1:0]  b_dx_r, b_dy_r;
  logic [RW-1:0]         b_r_r;
  logic [SQW-1:0]        b_sqx_r, b_sqy_r;
  logic [R2W-1:0]        b_r2_r;
  logic [SQW-1:0]        b_sqx_nxt, b_sqy_nxt;
  logic [R2W-1:0]        b_r2_nxt;
  logic signed [2*DW-1:0] sqx_full, sqy_full;

  osc_side_t       c_side_r, c_side_nxt;
  logic [RADW-1:0] c_rad_s_r, c_rad_l_r;
  logic [RADW-1:0] c_rad_s_nxt, c_rad_l_nxt;
  logic [D2W-1:0]  d2;
  logic [D2W-1:0]  r2_ext;

  // A stage loads when it is empty or when the stage after it moves.
  always_comb begin
    take[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      take[i] = !v_r[i] || take[i+1];
    end
    v_nxt = (take & {v_r[N-2:0], in_valid}) | (~take & v_r);
  end

  assign in_ready  = take[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage A: signed deltas from player to obstacle.
  always_comb begin
    a_dx_nxt = $signed({1'b0, in_ox}) - $signed({1'b0, in_px});
    a_dy_nxt = $signed({1'b0, in_oy}) - $signed({1'b0, in_py});
  end

  // Stage B: squares of the deltas and of the radius.
  always_comb begin
    sqx_full  = a_dx_r * a_dx_r;
    sqy_full  = a_dy_r * a_dy_r;
    b_sqx_nxt = sqx_full[SQW-1:0];
    b_sqy_nxt = sqy_full[SQW-1:0];
    b_r2_nxt  = R2W'(a_r_r) * R2W'(a_r_r);
  end

  // Stage C: squared distance, too-close test and the two radicands.
  always_comb begin
    d2          = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
    r2_ext      = {{(D2W-R2W){1'b0}}, b_r2_r};
    c_side_nxt.px    = b_px_r;
    c_side_nxt.py    = b_py_r;
    c_side_nxt.dx    = b_dx_r;
    c_side_nxt.dy    = b_dy_r;
    c_side_nxt.d2    = d2;
    c_side_nxt.r     = b_r_r;
    c_side_nxt.close = (d2 <= r2_ext);
    c_rad_s_nxt = (d2 <= r2_ext) ? '0 : {1'b0, d2 - r2_ext};
    c_rad_l_nxt = {1'b0, d2} + {{(RADW-R2W){1'b0}}, b_r2_r};
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      a_px_r <= in_px;
      a_py_r <= in_py;
      a_dx_r <= a_dx_nxt;
      a_dy_r <= a_dy_nxt;
      a_r_r  <= in_radius;
    end
    if (take[1]) begin
      b_px_r  <= a_px_r;
      b_py_r  <= a_py_r;
      b_dx_r  <= a_dx_r;
      b_dy_r  <= a_dy_r;
      b_r_r   <= a_r_r;
      b_sqx_r <= b_sqx_nxt;
      b_sqy_r <= b_sqy_nxt;
      b_r2_r  <= b_r2_nxt;
    end
    if (take[2]) begin
      c_side_r  <= c_side_nxt;
      c_rad_s_r <= c_rad_s_nxt;
      c_rad_l_r <= c_rad_l_nxt;
    end
  end

  assign out_side  = c_side_r;
  assign out_rad_s = c_rad_s_r;
  assign out_rad_l = c_rad_l_r;

endmodule
`default_nettype wire

### rtl/osc_root.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osc_root: pipelined Q16 square roots
// Two digit-by-digit roots run side by side, one result bit per stage:
// s = sqrt(d2 - r2) and L = sqrt(d2 + r2), both with 16 fraction bits.
// ---------------------------------------------------------------------------
module osc_root
  import osc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  osc_side_t        in_side,
  input  logic [RADW-1:0]  in_rad_s,
  input  logic [RADW-1:0]  in_rad_l,
  output logic             out_valid,
  input  logic             out_ready,
  output osc_side_t        out_side,
  output logic [ROOTW-1:0] out_s,
  output logic [ROOTW-1:0] out_len
);

  localparam int N = ROOTW;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N-1:0] take;

  osc_side_t      side_r [N];
  osc_root_lane_t s_r    [N];
  osc_root_lane_t l_r    [N];
  osc_side_t      src_side [N];
  osc_root_lane_t src_s    [N];
  osc_root_lane_t src_l    [N];
  osc_root_lane_t s_nxt    [N];
  osc_root_lane_t l_nxt    [N];

  // One root bit: bring down the next radicand pair and try 4*root+1.
  function automatic osc_root_lane_t root_step(osc_root_lane_t a);
    logic [REMW+1:0] cur;
    logic [REMW+1:0] trial;
    logic [REMW+1:0] diff;
    osc_root_lane_t  b;
    cur   = {a.rem, a.rad[2*ROOTW-1 -: 2]};
    trial = {2'b00, a.root, 2'b01};
    diff  = cur - trial;
    b.rad = {a.rad[2*ROOTW-3:0], 2'b00};
    if (cur >= trial) begin
      b.rem  = diff[REMW-1:0];
      b.root = {a.root[ROOTW-2:0], 1'b1};
    end else begin
      b.rem  = cur[REMW-1:0];
      b.root = {a.root[ROOTW-2:0], 1'b0};
    end
    return b;
  endfunction

  // A stage loads when it is empty or when the stage after it moves.
  always_comb begin
    take[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      take[i] = !v_r[i] || take[i+1];
    end
    v_nxt = (take & {v_r[N-2:0], in_valid}) | (~take & v_r);
  end

  assign in_ready  = take[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage inputs, then one root step per stage and lane.
  always_comb begin
    src_side[0]    = in_side;
    src_s[0].rad   = {in_rad_s, {(2*FRAC){1'b0}}};
    src_s[0].rem   = '0;
    src_s[0].root  = '0;
    src_l[0].rad   = {in_rad_l, {(2*FRAC){1'b0}}};
    src_l[0].rem   = '0;
    src_l[0].root  = '0;
    for (int i = 1; i < N; i++) begin
      src_side[i] = side_r[i-1];
      src_s[i]    = s_r[i-1];
      src_l[i]    = l_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      s_nxt[i] = root_step(src_s[i]);
      l_nxt[i] = root_step(src_l[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (take[i]) begin
        side_r[i] <= src_side[i];
        s_r[i]    <= s_nxt[i];
        l_r[i]    <= l_nxt[i];
      end
    end
  end

  assign out_side = side_r[N-1];
  assign out_s    = s_r[N-1].root;
  assign out_len  = l_r[N-1].root;

endmodule
`default_nettype wire

### rtl/osc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osc_div: unit direction components
// Forms the four numerators dx*s -/+ dy*r*2^16 and dy*s +/- dx*r*2^16,
// then divides each by d2 in a restoring divider, one quotient bit per
// stage. Quotients come out as sign and magnitude, truncated toward zero.
// ---------------------------------------------------------------------------
module osc_div
  import osc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  osc_side_t                  in_side,
  input  logic [ROOTW-1:0]           in_s,
  input  logic [ROOTW-1:0]           in_len,
  output logic                       out_valid,
  input  logic                       out_ready,
  output osc_tail_t                  out_tail,
  output logic [NLANE-1:0]           out_neg,
  output logic [NLANE-1:0][QW-1:0]   out_mag
);

  localparam int N  = QW + 2;
  localparam int PW = DW + RW + 1;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N-1:0] take;

  // Product stage.
  osc_side_t             p_side_r;
  logic [ROOTW-1:0]      p_len_r;
  logic signed [NUMW-1:0] p_dxs_r, p_dys_r;
  logic signed [PW-1:0]  p_dxr_r, p_dyr_r;
  logic signed [NUMW-1:0] p_dxs_nxt, p_dys_nxt;
  logic signed [PW-1:0]  p_dxr_nxt, p_dyr_nxt;

  // Numerator stage.
  osc_tail_t             n_tail_r, n_tail_nxt;
  logic [D2W-1:0]        n_d2_r;
  osc_div_lane_t         n_lane_r   [NLANE];
  osc_div_lane_t         n_lane_nxt [NLANE];
  logic signed [NUMW-1:0] dxrq, dyrq;
  logic signed [NUMW-1:0] num    [NLANE];
  logic signed [NUMW-1:0] absnum [NLANE];

  // Divider stages.
  osc_tail_t     t_r    [QW];
  logic [D2W-1:0] d2_r  [QW];
  osc_div_lane_t dl_r   [QW][NLANE];
  osc_tail_t     src_t  [QW];
  logic [D2W-1:0] src_d2 [QW];
  osc_div_lane_t src_l  [QW][NLANE];
  osc_div_lane_t dl_nxt [QW][NLANE];

  // One restoring division step against the squared distance.
  function automatic osc_div_lane_t div_step(osc_div_lane_t a, logic [D2W-1:0] den);
    logic [DREMW-1:0] cur;
    osc_div_lane_t    b;
    cur   = {a.rem[D2W-1:0], a.bits[QW-1]};
    b.neg = a.neg;
    if (cur >= {1'b0, den}) begin
      b.rem  = cur - {1'b0, den};
      b.bits = {a.bits[QW-2:0], 1'b1};
    end else begin
      b.rem  = cur;
      b.bits = {a.bits[QW-2:0], 1'b0};
    end
    return b;
  endfunction

  // A stage loads when it is empty or when the stage after it moves.
  always_comb begin
    take[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      take[i] = !v_r[i] || take[i+1];
    end
    v_nxt = (take & {v_r[N-2:0], in_valid}) | (~take & v_r);
  end

  assign in_ready  = take[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Products of the deltas with the root and with the radius.
  always_comb begin
    p_dxs_nxt = in_side.dx * $signed({1'b0, in_s});
    p_dys_nxt = in_side.dy * $signed({1'b0, in_s});
    p_dxr_nxt = in_side.dx * $signed({1'b0, in_side.r});
    p_dyr_nxt = in_side.dy * $signed({1'b0, in_side.r});
  end

  // Numerators, split into sign and magnitude for the divider.
  always_comb begin
    dxrq = NUMW'(p_dxr_r) <<< FRAC;
    dyrq = NUMW'(p_dyr_r) <<< FRAC;
    num[LANE_C1] = p_dxs_r - dyrq;
    num[LANE_S1] = p_dys_r + dxrq;
    num[LANE_C2] = p_dxs_r + dyrq;
    num[LANE_S2] = p_dys_r - dxrq;
    for (int j = 0; j < NLANE; j++) begin
      absnum[j]          = num[j][NUMW-1] ? -num[j] : num[j];
      n_lane_nxt[j].neg  = num[j][NUMW-1];
      n_lane_nxt[j].rem  = {1'b0, absnum[j][MAGW-1:QW]};
      n_lane_nxt[j].bits = absnum[j][QW-1:0];
    end
    n_tail_nxt.px    = p_side_r.px;
    n_tail_nxt.py    = p_side_r.py;
    n_tail_nxt.len   = p_len_r;
    n_tail_nxt.close = p_side_r.close;
  end

  // Divider stage inputs and steps.
  always_comb begin
    src_t[0]  = n_tail_r;
    src_d2[0] = n_d2_r;
    for (int j = 0; j < NLANE; j++) begin
      src_l[0][j] = n_lane_r[j];
    end
    for (int k = 1; k < QW; k++) begin
      src_t[k]  = t_r[k-1];
      src_d2[k] = d2_r[k-1];
      for (int j = 0; j < NLANE; j++) begin
        src_l[k][j] = dl_r[k-1][j];
      end
    end
    for (int k = 0; k < QW; k++) begin
      for (int j = 0; j < NLANE; j++) begin
        dl_nxt[k][j] = div_step(src_l[k][j], src_d2[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      p_side_r <= in_side;
      p_len_r  <= in_len;
      p_dxs_r  <= p_dxs_nxt;
      p_dys_r  <= p_dys_nxt;
      p_dxr_r  <= p_dxr_nxt;
      p_dyr_r  <= p_dyr_nxt;
    end
    if (take[1]) begin
      n_tail_r <= n_tail_nxt;
      n_d2_r   <= p_side_r.d2;
      for (int j = 0; j < NLANE; j++) begin
        n_lane_r[j] <= n_lane_nxt[j];
      end
    end
    for (int k = 0; k < QW; k++) begin
      if (take[k+2]) begin
        t_r[k]  <= src_t[k];
        d2_r[k] <= src_d2[k];
        for (int j = 0; j < NLANE; j++) begin
          dl_r[k][j] <= dl_nxt[k][j];
        end
      end
    end
  end

  // Quotients after the last step.
  always_comb begin
    out_tail = t_r[QW-1];
    for (int j = 0; j < NLANE; j++) begin
      out_neg[j] = dl_r[QW-1][j].neg;
      out_mag[j] = dl_r[QW-1][j].bits;
    end
  end

endmodule
`default_nettype wire

### rtl/osc_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osc_scale: corner offsets and output register
// Multiplies the cone length by each unit component, drops the 32 fraction
// bits toward zero, adds the player position and saturates to 13 bits.
// ---------------------------------------------------------------------------
module osc_scale
  import osc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  osc_tail_t                in_tail,
  input  logic [NLANE-1:0]         in_neg,
  input  logic [NLANE-1:0][QW-1:0] in_mag,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUTW-1:0]   out_corner [NLANE],
  output logic                     out_close
);

  localparam int N = 2;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N-1:0] take;

  osc_tail_t          m_tail_r;
  logic [NLANE-1:0]   m_neg_r;
  logic [PRODW-1:0]   m_prod_r   [NLANE];
  logic [PRODW-1:0]   m_prod_nxt [NLANE];

  logic signed [OUTW-1:0] corner_r   [NLANE];
  logic signed [OUTW-1:0] corner_nxt [NLANE];
  logic                   close_r;

  logic [OFFW-1:0]        off  [NLANE];
  logic signed [SUMW-1:0] base [NLANE];
  logic signed [SUMW-1:0] sum  [NLANE];

  // Clamp a corner into the signed 13-bit output range.
  function automatic logic signed [OUTW-1:0] sat(logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] c;
    if (v > OUT_MAX) begin
      c = OUT_MAX;
    end else if (v < OUT_MIN) begin
      c = OUT_MIN;
    end else begin
      c = v;
    end
    return c[OUTW-1:0];
  endfunction

  // A stage loads when it is empty or when the stage after it moves.
  always_comb begin
    take[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      take[i] = !v_r[i] || take[i+1];
    end
    v_nxt = (take & {v_r[N-2:0], in_valid}) | (~take & v_r);
  end

  assign in_ready  = take[0];
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Length times unit magnitude; the sign is applied after truncation.
  always_comb begin
    for (int j = 0; j < NLANE; j++) begin
      m_prod_nxt[j] = PRODW'(in_tail.len) * PRODW'(in_mag[j]);
    end
  end

  // Offset, player position and saturation; too close keeps the player.
  always_comb begin
    for (int j = 0; j < NLANE; j++) begin
      off[j]  = m_prod_r[j][PRODW-1:2*FRAC];
      base[j] = (j == LANE_C1 || j == LANE_C2) ?
                $signed({{(SUMW-COORD_BITS){1'b0}}, m_tail_r.px}) :
                $signed({{(SUMW-COORD_BITS){1'b0}}, m_tail_r.py});
      if (m_tail_r.close) begin
        sum[j] = base[j];
      end else if (m_neg_r[j]) begin
        sum[j] = base[j] - $signed({{(SUMW-OFFW){1'b0}}, off[j]});
      end else begin
        sum[j] = base[j] + $signed({{(SUMW-OFFW){1'b0}}, off[j]});
      end
      corner_nxt[j] = sat(sum[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      m_tail_r <= in_tail;
      m_neg_r  <= in_neg;
      for (int j = 0; j < NLANE; j++) begin
        m_prod_r[j] <= m_prod_nxt[j];
      end
    end
    if (take[1]) begin
      close_r <= m_tail_r.close;
      for (int j = 0; j < NLANE; j++) begin
        corner_r[j] <= corner_nxt[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NLANE; j++) begin
      out_corner[j] = corner_r[j];
    end
  end
  assign out_close = close_r;

endmodule
`default_nettype wire

### rtl/obstacle_shadow_cone_points_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// obstacle_shadow_cone_points_core: shadow cone corners of one obstacle
// Given a player and an obstacle centre, returns the two tangent corners of
// the cone that clears the obstacle by the programmed radius, or the player
// position with too_close set when the player is within that radius.
// ---------------------------------------------------------------------------
// The core takes one request per clock while in_stall is low and returns one
// result per request, in order, through 3 front-end stages, 27 square-root
// stages (one root bit each, both roots side by side), a product stage and a
// numerator stage, 17 divider stages (one quotient bit each) and 2 scaling
// stages. Every stage loads whenever it or a stage after it is empty, so a
// stalled output still lets requests move up into free stages.
// The clearance radius is sampled as a request enters; change it only while
// no request is in flight.
module obstacle_shadow_cone_points_core
  import osc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_BITS-1:0]  in_player_x,
  input  logic [COORD_BITS-1:0]  in_player_y,
  input  logic [COORD_BITS-1:0]  in_obstacle_x,
  input  logic [COORD_BITS-1:0]  in_obstacle_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [OUTW-1:0] out_first_corner_x,
  output logic signed [OUTW-1:0] out_first_corner_y,
  output logic signed [OUTW-1:0] out_second_corner_x,
  output logic signed [OUTW-1:0] out_second_corner_y,
  output logic                   out_too_close,
  input  logic                   cfg_wr_en,
  input  logic [RW-1:0]          cfg_wr_data
);

  logic [RW-1:0] radius_r, radius_nxt;

  logic             fe_in_ready;
  logic             fe_valid, rt_ready;
  osc_side_t        fe_side;
  logic [RADW-1:0]  fe_rad_s, fe_rad_l;

  logic             rt_valid, dv_ready;
  osc_side_t        rt_side;
  logic [ROOTW-1:0] rt_s, rt_len;

  logic                     dv_valid, sc_ready;
  osc_tail_t                dv_tail;
  logic [NLANE-1:0]         dv_neg;
  logic [NLANE-1:0][QW-1:0] dv_mag;

  logic signed [OUTW-1:0] sc_corner [NLANE];

  // Clearance radius register.
  always_comb begin
    radius_nxt = cfg_wr_en ? cfg_wr_data : radius_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else begin
      radius_r <= radius_nxt;
    end
  end

  assign in_stall = !fe_in_ready;

  osc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (fe_in_ready),
    .in_px     (in_player_x),
    .in_py     (in_player_y),
    .in_ox     (in_obstacle_x),
    .in_oy     (in_obstacle_y),
    .in_radius (radius_r),
    .out_valid (fe_valid),
    .out_ready (rt_ready),
    .out_side  (fe_side),
    .out_rad_s (fe_rad_s),
    .out_rad_l (fe_rad_l)
  );

  osc_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_ready  (rt_ready),
    .in_side   (fe_side),
    .in_rad_s  (fe_rad_s),
    .in_rad_l  (fe_rad_l),
    .out_valid (rt_valid),
    .out_ready (dv_ready),
    .out_side  (rt_side),
    .out_s     (rt_s),
    .out_len   (rt_len)
  );

  osc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_valid),
    .in_ready  (dv_ready),
    .in_side   (rt_side),
    .in_s      (rt_s),
    .in_len    (rt_len),
    .out_valid (dv_valid),
    .out_ready (sc_ready),
    .out_tail  (dv_tail),
    .out_neg   (dv_neg),
    .out_mag   (dv_mag)
  );

  osc_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dv_valid),
    .in_ready   (sc_ready),
    .in_tail    (dv_tail),
    .in_neg     (dv_neg),
    .in_mag     (dv_mag),
    .out_valid  (out_valid),
    .out_ready  (!out_stall),
    .out_corner (sc_corner),
    .out_close  (out_too_close)
  );

  assign out_first_corner_x  = sc_corner[LANE_C1];
  assign out_first_corner_y  = sc_corner[LANE_S1];
  assign out_second_corner_x = sc_corner[LANE_C2];
  assign out_second_corner_y = sc_corner[LANE_S2];

endmodule
`default_nettype wire
